// ===== src/btsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btsm_pkg: shared types and constants of the bus traffic statistics monitor
// table sizes, hash constant, reset threshold, controller states and command/status structs
// ----------------------------------------------------------------------------
package btsm_pkg;

  localparam int STATUS_ENTRIES = 32;
  localparam int SIDX_W = $clog2(STATUS_ENTRIES);
  localparam int SCNT_W = $clog2(STATUS_ENTRIES + 1);
  localparam int ID_ENTRIES = 4096;
  localparam int ID_W = $clog2(ID_ENTRIES);
  localparam int IDCNT_W = $clog2(ID_ENTRIES + 1);
  localparam int ID_HALF = ID_ENTRIES / 2;
  localparam logic [31:0] HASH_MULT = 32'd2654435761;
  localparam logic [31:0] THRESH_RESET = 32'd10000;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_HASH,
    ST_PROBE,
    ST_CHECK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic load;
    logic scan_step;
    logic status_commit;
    logic hash_start;
    logic probe_read;
    logic probe_next;
    logic id_insert;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic scan_done;
    logic need_id;
    logic slot_free;
    logic key_match;
    logic probe_exhausted;
  } stat_t;

endpackage

// ===== src/btsm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btsm_ram: generic single-port ram
// one write or one read per cycle, registered read data
// ----------------------------------------------------------------------------
module btsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ===== src/btsm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btsm_ctrl: controller of the statistics monitor
// sequences clear pass, status scan, hash probe and result hand-off
// ----------------------------------------------------------------------------
module btsm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire btsm_pkg::stat_t   st,
  output btsm_pkg::cmd_t         cmd
);

  btsm_pkg::state_t state, state_next;
  logic             busy, busy_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= btsm_pkg::ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign busy = 1'b0;
  assign busy_next = busy;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      btsm_pkg::ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (st.clear_done) begin
          state_next = btsm_pkg::ST_IDLE;
        end
      end
      btsm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = btsm_pkg::ST_SCAN;
        end
      end
      btsm_pkg::ST_SCAN: begin
        if (st.scan_done) begin
          cmd.status_commit = 1'b1;
          state_next = st.need_id ? btsm_pkg::ST_HASH : btsm_pkg::ST_DONE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      btsm_pkg::ST_HASH: begin
        cmd.hash_start = 1'b1;
        state_next = btsm_pkg::ST_PROBE;
      end
      btsm_pkg::ST_PROBE: begin
        cmd.probe_read = 1'b1;
        state_next = btsm_pkg::ST_CHECK;
      end
      btsm_pkg::ST_CHECK: begin
        if (st.slot_free) begin
          cmd.id_insert = 1'b1;
          state_next = btsm_pkg::ST_DONE;
        end else if (st.key_match || st.probe_exhausted) begin
          state_next = btsm_pkg::ST_DONE;
        end else begin
          cmd.probe_next = 1'b1;
          state_next = btsm_pkg::ST_PROBE;
        end
      end
      btsm_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.finish = 1'b1;
          state_next = btsm_pkg::ST_IDLE;
        end
      end
      default: state_next = btsm_pkg::ST_IDLE;
    endcase
    if (busy_next) begin
      in_ready = 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == btsm_pkg::ST_IDLE) else $error("ready outside idle");
  a_finish_room: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || out_ready)) else $error("result overwritten");
  a_load_next: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == btsm_pkg::ST_SCAN) else $error("load lost");
  a_insert_free: assert property (@(posedge clk) disable iff (rst)
    cmd.id_insert |-> st.slot_free) else $error("insert into used slot");
`endif

endmodule
`default_nettype wire

// ===== src/btsm_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btsm_datapath: statistics datapath
// status table scan, identifier hash set in ram, gap and count registers
// ----------------------------------------------------------------------------
module btsm_datapath (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire btsm_pkg::cmd_t  cmd,
  output btsm_pkg::stat_t      st,
  input  wire logic            cfg_we,
  input  wire logic [31:0]     cfg_data,
  input  wire logic [31:0]     rx_status,
  input  wire logic            has_identifier,
  input  wire logic [31:0]     identifier,
  input  wire logic [31:0]     timestamp_us,
  output logic [63:0]          total_messages,
  output logic [11:0]          unique_identifiers,
  output logic [31:0]          largest_gap_us,
  output logic [63:0]          long_gap_count,
  output logic [31:0]          span_us,
  output logic [5:0]           distinct_statuses,
  output logic [31:0]          status_tally,
  output logic                 status_tracked
);

  logic [31:0] threshold;
  logic [31:0] req_status, req_id, req_ts;
  logic        req_has_id;
  logic [31:0] status_words [btsm_pkg::STATUS_ENTRIES];
  logic [31:0] status_counters [btsm_pkg::STATUS_ENTRIES];
  logic [btsm_pkg::SCNT_W-1:0] used;
  logic [btsm_pkg::SCNT_W-1:0] scan;
  logic        hit;
  logic [btsm_pkg::SIDX_W-1:0] hit_idx;
  logic [63:0] message_total, long_gaps;
  logic [31:0] first_time, last_time, max_gap, gap;
  logic        time_seen;
  logic [btsm_pkg::IDCNT_W-1:0] id_count;
  logic [btsm_pkg::ID_W-1:0] pos, clr_addr;
  logic [btsm_pkg::IDCNT_W-1:0] probes;
  logic [31:0] hash_prod;
  logic        ram_we;
  logic [btsm_pkg::ID_W-1:0] ram_addr;
  logic [32:0] ram_wdata, ram_rdata;
  logic [btsm_pkg::SIDX_W-1:0] scan_idx, used_idx;
  logic [31:0] tally_next;
  logic [31:0] tally_hold;
  logic        tracked_hold;

  assign scan_idx = scan[btsm_pkg::SIDX_W-1:0];
  assign used_idx = used[btsm_pkg::SIDX_W-1:0];
  assign hash_prod = req_id * btsm_pkg::HASH_MULT;
  assign gap = req_ts - last_time;

  assign ram_we = cmd.clear_step || cmd.id_insert;
  assign ram_addr = cmd.clear_step ? clr_addr : pos;
  assign ram_wdata = cmd.clear_step ? 33'd0 : {1'b1, req_id};

  btsm_ram #(.WIDTH(33), .DEPTH(btsm_pkg::ID_ENTRIES)) u_id_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    st.clear_done = (clr_addr == btsm_pkg::ID_W'(btsm_pkg::ID_ENTRIES - 1));
    st.scan_done = hit || (scan == used);
    st.need_id = req_has_id && (id_count < btsm_pkg::IDCNT_W'(btsm_pkg::ID_HALF));
    st.slot_free = !ram_rdata[32];
    st.key_match = ram_rdata[31:0] == req_id;
    st.probe_exhausted = probes == btsm_pkg::IDCNT_W'(btsm_pkg::ID_ENTRIES - 1);
    tally_next = (status_counters[hit_idx] != '1) ? status_counters[hit_idx] + 32'd1
                                                  : status_counters[hit_idx];
  end

  always_ff @(posedge clk) begin
    if (cfg_we) begin
      threshold <= cfg_data;
    end
    if (rst) begin
      threshold <= btsm_pkg::THRESH_RESET;
      clr_addr <= '0;
      used <= '0;
      id_count <= '0;
      message_total <= '0;
      long_gaps <= '0;
      first_time <= '0;
      last_time <= '0;
      max_gap <= '0;
      time_seen <= 1'b0;
      hit <= 1'b0;
      scan <= '0;
    end else begin
      if (cmd.clear_step) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.load) begin
        req_status <= rx_status;
        req_has_id <= has_identifier;
        req_id <= identifier;
        req_ts <= timestamp_us;
        scan <= '0;
        hit <= 1'b0;
      end
      if (cmd.scan_step) begin
        if (status_words[scan_idx] == req_status) begin
          hit <= 1'b1;
          hit_idx <= scan_idx;
        end else begin
          scan <= scan + 1'b1;
        end
      end
      if (cmd.status_commit) begin
        if (message_total != '1) begin
          message_total <= message_total + 64'd1;
        end
        if (hit) begin
          status_counters[hit_idx] <= tally_next;
          tally_hold <= tally_next;
          tracked_hold <= 1'b1;
        end else if (used != btsm_pkg::SCNT_W'(btsm_pkg::STATUS_ENTRIES)) begin
          status_words[used_idx] <= req_status;
          status_counters[used_idx] <= 32'd1;
          used <= used + 1'b1;
          tally_hold <= 32'd1;
          tracked_hold <= 1'b1;
        end else begin
          tally_hold <= '0;
          tracked_hold <= 1'b0;
        end
        if (!time_seen) begin
          first_time <= req_ts;
          time_seen <= 1'b1;
        end else begin
          if (gap > max_gap) begin
            max_gap <= gap;
          end
          if (gap > threshold && long_gaps != '1) begin
            long_gaps <= long_gaps + 64'd1;
          end
        end
        last_time <= req_ts;
      end
      if (cmd.hash_start) begin
        pos <= hash_prod[btsm_pkg::ID_W-1:0];
        probes <= '0;
      end
      if (cmd.probe_next) begin
        pos <= pos + 1'b1;
        probes <= probes + 1'b1;
      end
      if (cmd.id_insert) begin
        id_count <= id_count + 1'b1;
      end
      // result snapshot, held while the result waits
      if (cmd.finish) begin
        total_messages <= message_total;
        unique_identifiers <= 12'(id_count);
        largest_gap_us <= max_gap;
        long_gap_count <= long_gaps;
        span_us <= last_time - first_time;
        distinct_statuses <= 6'(used);
        status_tally <= tally_hold;
        status_tracked <= tracked_hold;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= btsm_pkg::SCNT_W'(btsm_pkg::STATUS_ENTRIES)) else $error("status table overrun");
  a_id_bound: assert property (@(posedge clk) disable iff (rst)
    id_count <= btsm_pkg::IDCNT_W'(btsm_pkg::ID_HALF)) else $error("hash set overfilled");
  a_total_moves: assert property (@(posedge clk) disable iff (rst)
    cmd.status_commit |=> message_total != 64'd0) else $error("total not counted");
`endif

endmodule
`default_nettype wire

// ===== src/bus_traffic_statistics_monitor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bus_traffic_statistics_monitor: bus message statistics
// counts messages, status words, distinct identifiers and timestamp gaps
//
// channel  direction  handshake            payload
// in       sink       in_valid/in_ready    rx_status has_identifier identifier timestamp_us
// out      source     out_valid/out_ready  total_messages .. status_tracked
// cfg      sink       cfg_we               cfg_data (long gap threshold)
//
// after reset, before any request is taken, a clearing pass empties the identifier set
// load, scan of up to 32 status entries, then if needed a hash and a read/check per probe
// probes go one ram read at a time through the identifier ram port
// a waiting result does not block acceptance of the next request until done
// ----------------------------------------------------------------------------
module bus_traffic_statistics_monitor (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] rx_status,
  input  wire logic        has_identifier,
  input  wire logic [31:0] identifier,
  input  wire logic [31:0] timestamp_us,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      total_messages,
  output logic [11:0]      unique_identifiers,
  output logic [31:0]      largest_gap_us,
  output logic [63:0]      long_gap_count,
  output logic [31:0]      span_us,
  output logic [5:0]       distinct_statuses,
  output logic [31:0]      status_tally,
  output logic             status_tracked,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_data
);

  btsm_pkg::cmd_t  cmd;
  btsm_pkg::stat_t st;

  btsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  btsm_datapath u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .st                 (st),
    .cfg_we             (cfg_we),
    .cfg_data           (cfg_data),
    .rx_status          (rx_status),
    .has_identifier     (has_identifier),
    .identifier         (identifier),
    .timestamp_us       (timestamp_us),
    .total_messages     (total_messages),
    .unique_identifiers (unique_identifiers),
    .largest_gap_us     (largest_gap_us),
    .long_gap_count     (long_gap_count),
    .span_us            (span_us),
    .distinct_statuses  (distinct_statuses),
    .status_tally       (status_tally),
    .status_tracked     (status_tracked)
  );

endmodule
`default_nettype wire

// ===== verif/bus_traffic_statistics_monitor_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bus_traffic_statistics_monitor_tb: self-checking bench for the statistics monitor
// a directed stimulus table, then random messages with random gaps on both sides;
// every result is compared field by field against an in-bench statistics model
// ----------------------------------------------------------------------------
module bus_traffic_statistics_monitor_tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DIR_ROWS = 14;
  localparam int RAND_ITEMS = 700;
  localparam logic [63:0] ALL64 = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [31:0] status;
    logic        has_id;
    logic [31:0] id;
    logic [31:0] ts;
  } msg_t;

  typedef struct packed {
    logic [63:0] total;
    logic [11:0] uniq;
    logic [31:0] max_gap;
    logic [63:0] long_cnt;
    logic [31:0] span;
    logic [5:0]  nstat;
    logic [31:0] tally;
    logic        tracked;
  } stats_t;

  typedef struct {
    msg_t   m;
    logic   known;
    stats_t want;
  } dir_row_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, out_ready = 0, cfg_we = 0;
  logic [31:0] rx_status = 0, identifier = 0, timestamp_us = 0, cfg_data = 0;
  logic has_identifier = 0;
  logic in_ready, out_valid, status_tracked;
  logic [63:0] total_messages, long_gap_count;
  logic [11:0] unique_identifiers;
  logic [31:0] largest_gap_us, span_us, status_tally;
  logic [5:0] distinct_statuses;

  bus_traffic_statistics_monitor uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .rx_status(rx_status), .has_identifier(has_identifier),
    .identifier(identifier), .timestamp_us(timestamp_us),
    .out_valid(out_valid), .out_ready(out_ready),
    .total_messages(total_messages), .unique_identifiers(unique_identifiers),
    .largest_gap_us(largest_gap_us), .long_gap_count(long_gap_count),
    .span_us(span_us), .distinct_statuses(distinct_statuses),
    .status_tally(status_tally), .status_tracked(status_tracked),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // model state
  logic [31:0] threshold;
  logic [31:0] st_word [btsm_pkg::STATUS_ENTRIES];
  logic [31:0] st_cnt [btsm_pkg::STATUS_ENTRIES];
  int          st_used;
  logic [31:0] id_key [btsm_pkg::ID_ENTRIES];
  bit          id_used [btsm_pkg::ID_ENTRIES];
  int          id_cnt;
  logic [63:0] msg_cnt, long_cnt;
  logic [31:0] t_first, t_last, gap_max;
  bit          t_seen;

  stats_t expected_stats[$];
  bit     known_flag[$];
  stats_t known_want[$];
  int     errors = 0;
  int     idle_cycles = 0;
  bit     drain_out = 0;
  dir_row_t dir_tab[DIR_ROWS];

  function automatic void clear_stats_model();
    st_used = 0; id_cnt = 0; msg_cnt = 0; long_cnt = 0;
    t_first = 0; t_last = 0; gap_max = 0; t_seen = 0;
    threshold = btsm_pkg::THRESH_RESET;
    foreach (id_used[i]) id_used[i] = 0;
  endfunction

  function automatic stats_t update_stats(msg_t m);
    stats_t r;
    int i;
    logic [31:0] pos, gap;
    bit found;
    found = 0;
    r.tally = 0; r.tracked = 0;
    if (msg_cnt != ALL64) msg_cnt++;
    for (i = 0; i < st_used; i++)
      if (!found && st_word[i] == m.status) begin
        if (st_cnt[i] != 32'hFFFF_FFFF) st_cnt[i]++;
        r.tally = st_cnt[i]; r.tracked = 1; found = 1;
      end
    if (!found && st_used < btsm_pkg::STATUS_ENTRIES) begin
      st_word[st_used] = m.status; st_cnt[st_used] = 1; st_used++;
      r.tally = 1; r.tracked = 1;
    end
    if (m.has_id && id_cnt < btsm_pkg::ID_HALF) begin
      pos = (m.id * btsm_pkg::HASH_MULT) & (btsm_pkg::ID_ENTRIES - 1);
      for (i = 0; i < btsm_pkg::ID_ENTRIES; i++) begin
        if (!id_used[pos]) begin
          id_used[pos] = 1; id_key[pos] = m.id; id_cnt++; break;
        end
        if (id_key[pos] == m.id) break;
        pos = (pos + 1) & (btsm_pkg::ID_ENTRIES - 1);
      end
    end
    if (!t_seen) begin
      t_first = m.ts; t_seen = 1;
    end else begin
      gap = m.ts - t_last;
      if (gap > gap_max) gap_max = gap;
      if (gap > threshold && long_cnt != ALL64) long_cnt++;
    end
    t_last = m.ts;
    r.total = msg_cnt; r.uniq = id_cnt[11:0]; r.max_gap = gap_max;
    r.long_cnt = long_cnt; r.span = t_last - t_first; r.nstat = st_used[5:0];
    return r;
  endfunction

  task automatic send_request(msg_t m, bit known, stats_t want);
    int w;
    w = $urandom_range(0, 14);
    if ($urandom_range(0, 3) == 0) w = 0;
    if (w > 0) begin
      in_valid <= 0;
      repeat (w) @(posedge clk);
    end
    expected_stats.push_back(update_stats(m));
    known_flag.push_back(known);
    known_want.push_back(want);
    in_valid <= 1;
    rx_status <= m.status; has_identifier <= m.has_id;
    identifier <= m.id; timestamp_us <= m.ts;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_threshold(logic [31:0] v);
    in_valid <= 0;
    while (expected_stats.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    cfg_we <= 1; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    threshold = v;
  endtask

  // result side
  always @(posedge clk) begin
    stats_t got, want, row;
    if (!rst && out_valid && out_ready) begin
      got = '{total_messages, unique_identifiers, largest_gap_us, long_gap_count,
              span_us, distinct_statuses, status_tally, status_tracked};
      if (expected_stats.size() == 0) begin
        $display("%0t unexpected result %p", $time, got);
        errors++;
      end else begin
        want = expected_stats.pop_front();
        row = known_want.pop_front();
        if (known_flag.pop_front()) begin
          if (row !== want) begin
            $display("%0t table row exp %p model %p", $time, row, want);
            errors++;
          end
        end
        if (got.total !== want.total)
          $display("%0t total exp %0d got %0d", $time, want.total, got.total);
        if (got.uniq !== want.uniq)
          $display("%0t unique exp %0d got %0d", $time, want.uniq, got.uniq);
        if (got.max_gap !== want.max_gap)
          $display("%0t max gap exp %0d got %0d", $time, want.max_gap, got.max_gap);
        if (got.long_cnt !== want.long_cnt)
          $display("%0t long gaps exp %0d got %0d", $time, want.long_cnt, got.long_cnt);
        if (got.span !== want.span)
          $display("%0t span exp %0d got %0d", $time, want.span, got.span);
        if (got.nstat !== want.nstat)
          $display("%0t statuses exp %0d got %0d", $time, want.nstat, got.nstat);
        if (got.tally !== want.tally)
          $display("%0t tally exp %0d got %0d", $time, want.tally, got.tally);
        if (got.tracked !== want.tracked)
          $display("%0t tracked exp %0d got %0d", $time, want.tracked, got.tracked);
        if (got !== want) errors++;
      end
    end
  end

  // receiver stalls
  initial begin
    int w;
    @(negedge rst);
    forever begin
      w = drain_out ? 0 : $urandom_range(0, 14);
      if ($urandom_range(0, 3) == 0) w = 0;
      if (w > 0) begin
        out_ready <= 0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (!in_valid && expected_stats.size() == 0))
      idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    msg_t m;
    stats_t z;
    int i, k, phase;
    logic [31:0] ts;
    z = '0;
    clear_stats_model();
    // typed-in rows only where the outcome is obvious
    dir_tab[0]  = '{'{32'h0, 1, 32'h0, 32'h0}, 1,
                    '{64'd1, 12'd1, 32'd0, 64'd0, 32'd0, 6'd1, 32'd1, 1'b1}};
    dir_tab[1]  = '{'{32'h0, 1, 32'h0, 32'd10000}, 1,
                    '{64'd2, 12'd1, 32'd10000, 64'd0, 32'd10000, 6'd1, 32'd2, 1'b1}};
    dir_tab[2]  = '{'{32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 32'd20001}, 1,
                    '{64'd3, 12'd2, 32'd10001, 64'd1, 32'd20001, 6'd2, 32'd1, 1'b1}};
    dir_tab[3]  = '{'{32'hFFFF_FFFF, 0, 32'h1234_5678, 32'd20001}, 0, z};
    dir_tab[4]  = '{'{32'hA5A5_5A5A, 1, 32'h1234_5678, 32'd5}, 0, z};
    dir_tab[5]  = '{'{32'h0, 1, 32'h1234_5678, 32'hFFFF_FFFF}, 0, z};
    dir_tab[6]  = '{'{32'h5A5A_A5A5, 1, 32'h0000_1000, 32'h0}, 0, z};
    dir_tab[7]  = '{'{32'h5A5A_A5A5, 1, 32'h0000_2000, 32'h10}, 0, z};
    dir_tab[8]  = '{'{32'h0000_0001, 1, 32'h8000_0000, 32'h20}, 0, z};
    dir_tab[9]  = '{'{32'h8000_0000, 1, 32'h7FFF_FFFF, 32'h8000_0000}, 0, z};
    dir_tab[10] = '{'{32'h0000_0001, 1, 32'h0000_1000, 32'h7FFF_FFFF}, 0, z};
    dir_tab[11] = '{'{32'h1, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF}, 0, z};
    dir_tab[12] = '{'{32'h2, 1, 32'h0000_3000, 32'h8000_0001}, 0, z};
    dir_tab[13] = '{'{32'h3, 1, 32'h0000_0001, 32'h8000_2712}, 0, z};
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    for (i = 0; i < DIR_ROWS; i++)
      send_request(dir_tab[i].m, dir_tab[i].known, dir_tab[i].want);
    write_threshold(32'd0);
    ts = 32'h100;
    for (phase = 0; phase < 4; phase++) begin
      for (k = 0; k < RAND_ITEMS / 4; k++) begin
        case ($urandom_range(0, 3))
          0: m.status = $urandom_range(0, 40);
          1: m.status = $urandom;
          default: m.status = $urandom_range(0, 10);
        endcase
        m.has_id = ($urandom_range(0, 7) != 0);
        m.id = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 300) : $urandom;
        if ($urandom_range(0, 1) == 0) m.id = m.id << 12;
        case ($urandom_range(0, 7))
          0: ts = $urandom;
          1: ts = ts - $urandom_range(0, 100);
          2: ts = ts + threshold;
          3: ts = ts + threshold + 1;
          default: ts = ts + $urandom_range(0, 20000);
        endcase
        m.ts = ts;
        send_request(m, 0, z);
      end
      case (phase)
        0: write_threshold(32'hFFFF_FFFF);
        1: write_threshold($urandom);
        2: write_threshold(32'd10000);
        default: ;
      endcase
    end
    in_valid <= 0;
    drain_out = 1;
    while (expected_stats.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
